[src/mdd_pkg.sv]
// ----------------------------------------------------------------------------
// mdd_pkg
// Shared constants, datapath commands and status for the maximum drawdown
// with recovery block.
// ----------------------------------------------------------------------------
package mdd_pkg;

  // column storage
  localparam int MAX_ROWS  = 1024;
  localparam int IDX_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = $clog2(MAX_ROWS + 1);

  // field widths
  localparam int RET_W     = 32;
  localparam int DATE_W    = 64;
  localparam int WEALTH_W  = 64;
  localparam int DD_W      = 33;
  localparam int OIDX_W    = 10;
  localparam int RET_FRAC  = 24;

  // drawdown divider
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [WEALTH_W-1:0]  ONE_Q32 = 64'h0000_0001_0000_0000;
  localparam logic signed [RET_W:0] ONE_Q24 = 33'sh0_0100_0000;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_HI,
    OP_MUL_LO,
    OP_STORE,
    OP_FILL_INIT,
    OP_FILL_READ,
    OP_FILL_STEP,
    OP_CHK_READ,
    OP_EMPTY_OUT,
    OP_PEAK_INIT,
    OP_PK_READ,
    OP_PK_EVAL,
    OP_DIV_STEP,
    OP_PK_WRITE,
    OP_REC_INIT,
    OP_REC_READ,
    OP_REC_EVAL,
    OP_DATE_READ,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic missing;
    logic last;
    logic idx_zero;
    logic idx_last;
    logic rd_missing;
    logic div_done;
    logic rec_end;
    logic rec_hit;
    logic out_free;
  } stat_t;

endpackage

[src/mdd_if.sv]
// ----------------------------------------------------------------------------
// mdd_in_if / mdd_out_if
// Valid/ready channels for return rows and drawdown results.
// ----------------------------------------------------------------------------
interface mdd_in_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   period_return;
  logic                 is_missing;
  logic signed [63:0]   row_date;
  logic                 last_row;

  modport source (output valid, period_return, is_missing, row_date, last_row,
                  input ready);
  modport sink   (input valid, period_return, is_missing, row_date, last_row,
                  output ready);
endinterface

interface mdd_out_if;
  logic                 valid;
  logic                 ready;
  logic [32:0]          drawdown_depth;
  logic [9:0]           trough_index;
  logic signed [63:0]   trough_date;
  logic [9:0]           recovery_rows;
  logic                 recovered;
  logic                 all_missing;

  modport source (output valid, drawdown_depth, trough_index, trough_date,
                  recovery_rows, recovered, all_missing, input ready);
  modport sink   (input valid, drawdown_depth, trough_index, trough_date,
                  recovery_rows, recovered, all_missing, output ready);
endinterface

[src/max_drawdown_with_recovery.sv]
// ----------------------------------------------------------------------------
// max_drawdown_with_recovery
// Maximum drawdown, trough and recovery length over one column of returns.
// ----------------------------------------------------------------------------
// Usage:
//   rows   : one beat per row (return Q8.24, missing flag, date, last mark).
//            Up to 1024 rows are kept; later rows are dropped, but their last
//            mark still closes the column.
//   result : one beat per column, sent after the row marked last.
// Steps:
//   A valid row is latched, decided, multiplied as two 32x32 partial products
//   and stored; a missing row is latched, decided and stored. Closing a column
//   runs a back-fill pass, a peak pass (with the bit-serial drawdown divider)
//   and a recovery search, all through one read port.
// Reset: rst (synchronous) clears the column; stores need no clearing.
// Stall: the result sits in an output register; new rows are taken while it
//   waits, and only the next column's result waits for it to drain.
// ----------------------------------------------------------------------------
module max_drawdown_with_recovery (
  input  logic      clk,
  input  logic      rst,
  mdd_in_if.sink    rows,
  mdd_out_if.source result
);

  mdd_pkg::cmd_t  cmd;
  mdd_pkg::stat_t stat;

  mdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rows.valid),
    .in_ready (rows.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mdd_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .period_return (rows.period_return),
    .is_missing    (rows.is_missing),
    .row_date      (rows.row_date),
    .last_row      (rows.last_row),
    .result        (result)
  );

endmodule

[src/mdd_dpath.sv]
// ----------------------------------------------------------------------------
// mdd_dpath
// Column stores, wealth compounding, back-fill, peak/drawdown divider,
// recovery search and the result register.
// ----------------------------------------------------------------------------
module mdd_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  mdd_pkg::cmd_t                cmd,
  output mdd_pkg::stat_t               stat,
  input  logic signed [31:0]           period_return,
  input  logic                         is_missing,
  input  logic signed [63:0]           row_date,
  input  logic                         last_row,
  mdd_out_if.source                    result
);

  // column stores
  logic [mdd_pkg::WEALTH_W-1:0] wealth_mem  [mdd_pkg::MAX_ROWS];
  logic                         missing_mem [mdd_pkg::MAX_ROWS];
  logic [mdd_pkg::DATE_W-1:0]   date_mem    [mdd_pkg::MAX_ROWS];
  logic [mdd_pkg::WEALTH_W-1:0] peak_mem    [mdd_pkg::MAX_ROWS];

  // latched row
  logic [mdd_pkg::RET_W-1:0]    factor;
  logic                         miss_q;
  logic [mdd_pkg::DATE_W-1:0]   date_q;
  logic                         last_q;
  logic [63:0]                  ph;
  logic [63:0]                  pl;

  // column state
  logic [mdd_pkg::WEALTH_W-1:0] wealth;
  logic [mdd_pkg::CNT_W-1:0]    row_count;
  logic [mdd_pkg::CNT_W-1:0]    idx;
  logic [mdd_pkg::WEALTH_W-1:0] fill;
  logic                         have_fill;
  logic [mdd_pkg::WEALTH_W-1:0] peak;
  logic [mdd_pkg::WEALTH_W-1:0] rem;
  logic [mdd_pkg::DIV_STEPS-1:0] quo;
  logic [mdd_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [mdd_pkg::DD_W-1:0]     deepest;
  logic [mdd_pkg::IDX_W-1:0]    trough;
  logic [mdd_pkg::IDX_W-1:0]    rec;
  logic                         recd;

  // read port
  logic                         rd_en;
  logic [mdd_pkg::IDX_W-1:0]    rd_addr;
  logic [mdd_pkg::WEALTH_W-1:0] rd_wealth;
  logic                         rd_miss;
  logic [mdd_pkg::DATE_W-1:0]   rd_date;
  logic [mdd_pkg::WEALTH_W-1:0] rd_peak;

  // write port
  logic                         w_en;
  logic [mdd_pkg::IDX_W-1:0]    w_addr;
  logic [mdd_pkg::WEALTH_W-1:0] w_wealth;
  logic                         w_miss;
  logic                         d_en;
  logic                         p_en;

  // combinational helpers
  logic signed [mdd_pkg::RET_W:0] fsum;
  logic [64:0]                  gsum;
  logic [mdd_pkg::WEALTH_W-1:0] new_w;
  logic [mdd_pkg::WEALTH_W-1:0] pk_new;
  logic [mdd_pkg::WEALTH_W-1:0] rem_sh;
  logic                         take;

  // growth factor and saturating wealth product
  assign fsum  = {period_return[31], period_return} + mdd_pkg::ONE_Q24;
  assign gsum  = {1'b0, ph[55:0], 8'b0} + {25'b0, pl[63:24]};
  assign new_w = (ph[63:56] != '0 || gsum[64]) ? '1 : gsum[63:0];

  // peak update and divider step
  assign pk_new = (rd_wealth > peak) ? rd_wealth : peak;
  assign rem_sh = {rem[62:0], 1'b0};
  assign take   = rem[63] || (rem_sh >= peak);

  // memory port steering
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx[mdd_pkg::IDX_W-1:0];
    w_en     = 1'b0;
    w_addr   = idx[mdd_pkg::IDX_W-1:0];
    w_wealth = fill;
    w_miss   = 1'b0;
    d_en     = 1'b0;
    p_en     = 1'b0;
    case (cmd.op)
      mdd_pkg::OP_FILL_READ, mdd_pkg::OP_PK_READ, mdd_pkg::OP_REC_READ: begin
        rd_en = 1'b1;
      end
      mdd_pkg::OP_CHK_READ: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      mdd_pkg::OP_DATE_READ: begin
        rd_en   = 1'b1;
        rd_addr = trough;
      end
      mdd_pkg::OP_STORE: begin
        w_en     = 1'b1;
        d_en     = 1'b1;
        w_addr   = row_count[mdd_pkg::IDX_W-1:0];
        w_wealth = miss_q ? '0 : new_w;
        w_miss   = miss_q;
      end
      mdd_pkg::OP_FILL_STEP: begin
        w_en = rd_miss && have_fill;
      end
      mdd_pkg::OP_PK_WRITE: begin
        p_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // stores
  always_ff @(posedge clk) begin
    if (w_en) begin
      wealth_mem[w_addr]  <= w_wealth;
      missing_mem[w_addr] <= w_miss;
    end
    if (d_en) date_mem[w_addr] <= date_q;
    if (p_en) peak_mem[w_addr] <= peak;
    if (rd_en) begin
      rd_wealth <= wealth_mem[rd_addr];
      rd_miss   <= missing_mem[rd_addr];
      rd_date   <= date_mem[rd_addr];
      rd_peak   <= peak_mem[rd_addr];
    end
  end

  // row latch and multiplier stages
  always_ff @(posedge clk) begin
    case (cmd.op)
      mdd_pkg::OP_LOAD: begin
        factor <= fsum[mdd_pkg::RET_W] ? '0 : fsum[mdd_pkg::RET_W-1:0];
        miss_q <= is_missing;
        date_q <= row_date;
        last_q <= last_row;
      end
      mdd_pkg::OP_MUL_HI: ph <= wealth[63:32] * factor;
      mdd_pkg::OP_MUL_LO: pl <= wealth[31:0] * factor;
      default: begin
      end
    endcase
  end

  // column control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wealth    <= mdd_pkg::ONE_Q32;
      row_count <= '0;
      deepest   <= '0;
      trough    <= '0;
      idx       <= '0;
      have_fill <= 1'b0;
      div_cnt   <= '0;
      recd      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // result beat held until taken
      if (cmd.op == mdd_pkg::OP_EMIT || cmd.op == mdd_pkg::OP_EMPTY_OUT) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      case (cmd.op)
        mdd_pkg::OP_STORE: begin
          if (!miss_q) wealth <= new_w;
          row_count <= row_count + 1'b1;
        end
        mdd_pkg::OP_FILL_INIT: begin
          idx       <= row_count - 1'b1;
          have_fill <= 1'b0;
        end
        mdd_pkg::OP_FILL_STEP: begin
          if (!rd_miss) begin
            fill      <= rd_wealth;
            have_fill <= 1'b1;
          end
          idx <= idx - 1'b1;
        end
        mdd_pkg::OP_PEAK_INIT: begin
          peak <= rd_wealth;
          idx  <= '0;
        end
        mdd_pkg::OP_PK_EVAL: begin
          quo <= '0;
          if (!rd_miss) begin
            peak <= pk_new;
            rem  <= pk_new - rd_wealth;
            div_cnt <= (pk_new != '0 && rd_wealth < pk_new) ?
                       mdd_pkg::DIV_CNT_W'(mdd_pkg::DIV_STEPS) : '0;
          end else begin
            div_cnt <= '0;
          end
        end
        mdd_pkg::OP_DIV_STEP: begin
          rem     <= take ? rem_sh - peak : rem_sh;
          quo     <= {quo[mdd_pkg::DIV_STEPS-2:0], take};
          div_cnt <= div_cnt - 1'b1;
        end
        mdd_pkg::OP_PK_WRITE: begin
          if ({1'b0, quo} > deepest) begin
            deepest <= {1'b0, quo};
            trough  <= idx[mdd_pkg::IDX_W-1:0];
          end
          idx <= idx + 1'b1;
        end
        mdd_pkg::OP_REC_INIT: begin
          idx  <= {1'b0, trough} + 1'b1;
          rec  <= '0;
          recd <= 1'b0;
        end
        mdd_pkg::OP_REC_EVAL: begin
          if (stat.rec_hit) begin
            rec  <= idx[mdd_pkg::IDX_W-1:0] - trough;
            recd <= 1'b1;
          end
          idx <= idx + 1'b1;
        end
        mdd_pkg::OP_EMPTY_OUT: begin
          result.drawdown_depth <= '0;
          result.trough_index  <= '0;
          result.trough_date   <= rd_date;
          result.recovery_rows <= '0;
          result.recovered     <= 1'b0;
          result.all_missing   <= 1'b1;
          wealth    <= mdd_pkg::ONE_Q32;
          row_count <= '0;
          deepest   <= '0;
          trough    <= '0;
        end
        mdd_pkg::OP_EMIT: begin
          result.drawdown_depth <= deepest;
          result.trough_index  <= mdd_pkg::OIDX_W'(trough);
          result.trough_date   <= rd_date;
          result.recovery_rows <= (trough == '0) ? '0 : mdd_pkg::OIDX_W'(rec);
          result.recovered     <= (trough == '0) || recd;
          result.all_missing   <= 1'b0;
          wealth    <= mdd_pkg::ONE_Q32;
          row_count <= '0;
          deepest   <= '0;
          trough    <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // status to the controller
  always_comb begin
    stat.full       = (row_count == mdd_pkg::CNT_W'(mdd_pkg::MAX_ROWS));
    stat.missing    = miss_q;
    stat.last       = last_q;
    stat.idx_zero   = (idx == '0);
    stat.idx_last   = (idx == row_count - 1'b1);
    stat.rd_missing = rd_miss;
    stat.div_done   = (div_cnt == '0);
    stat.rec_end    = (idx >= row_count);
    stat.rec_hit    = !rd_miss && (rd_wealth >= rd_peak);
    stat.out_free   = !result.valid || result.ready;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= mdd_pkg::CNT_W'(mdd_pkg::MAX_ROWS))
    else $error("row count past store depth");

  a_trough_in_column: assert property (@(posedge clk) disable iff (rst)
    (row_count == '0) || ({1'b0, trough} < row_count))
    else $error("trough outside column");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (div_cnt != '0) |-> (rem <= peak))
    else $error("divider remainder above peak");

endmodule

[src/mdd_ctrl.sv]
// ----------------------------------------------------------------------------
// mdd_ctrl
// Sequencer: row intake, back-fill, peak/drawdown and recovery passes.
// ----------------------------------------------------------------------------
module mdd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mdd_pkg::stat_t stat,
  output mdd_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_MUL_HI, S_MUL_LO, S_STORE,
    S_FILL_INIT, S_FILL_RD, S_FILL_ST,
    S_CHK_RD, S_CHK, S_EMPTY,
    S_PK_RD, S_PK_EVAL, S_DIV, S_PK_WR,
    S_REC_INIT, S_REC_CHK, S_REC_RD, S_REC_EVAL,
    S_DATE_RD, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // command and next state
  always_comb begin
    cmd.op     = mdd_pkg::OP_NONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = mdd_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.full) state_next = stat.missing ? S_STORE : S_MUL_HI;
        else            state_next = stat.last ? S_FILL_INIT : S_IDLE;
      end
      S_MUL_HI: begin
        cmd.op = mdd_pkg::OP_MUL_HI; state_next = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op = mdd_pkg::OP_MUL_LO; state_next = S_STORE;
      end
      S_STORE: begin
        cmd.op     = mdd_pkg::OP_STORE;
        state_next = stat.last ? S_FILL_INIT : S_IDLE;
      end
      S_FILL_INIT: begin
        cmd.op = mdd_pkg::OP_FILL_INIT; state_next = S_FILL_RD;
      end
      S_FILL_RD: begin
        cmd.op = mdd_pkg::OP_FILL_READ; state_next = S_FILL_ST;
      end
      S_FILL_ST: begin
        cmd.op     = mdd_pkg::OP_FILL_STEP;
        state_next = stat.idx_zero ? S_CHK_RD : S_FILL_RD;
      end
      S_CHK_RD: begin
        cmd.op = mdd_pkg::OP_CHK_READ; state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.rd_missing) begin
          state_next = S_EMPTY;
        end else begin
          cmd.op     = mdd_pkg::OP_PEAK_INIT;
          state_next = S_PK_RD;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.op = mdd_pkg::OP_EMPTY_OUT; state_next = S_IDLE;
        end
      end
      S_PK_RD: begin
        cmd.op = mdd_pkg::OP_PK_READ; state_next = S_PK_EVAL;
      end
      S_PK_EVAL: begin
        cmd.op = mdd_pkg::OP_PK_EVAL; state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_PK_WR;
        else               cmd.op = mdd_pkg::OP_DIV_STEP;
      end
      S_PK_WR: begin
        cmd.op     = mdd_pkg::OP_PK_WRITE;
        state_next = stat.idx_last ? S_REC_INIT : S_PK_RD;
      end
      S_REC_INIT: begin
        cmd.op = mdd_pkg::OP_REC_INIT; state_next = S_REC_CHK;
      end
      S_REC_CHK: begin
        state_next = stat.rec_end ? S_DATE_RD : S_REC_RD;
      end
      S_REC_RD: begin
        cmd.op = mdd_pkg::OP_REC_READ; state_next = S_REC_EVAL;
      end
      S_REC_EVAL: begin
        cmd.op     = mdd_pkg::OP_REC_EVAL;
        state_next = stat.rec_hit ? S_DATE_RD : S_REC_CHK;
      end
      S_DATE_RD: begin
        cmd.op = mdd_pkg::OP_DATE_READ; state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = mdd_pkg::OP_EMIT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule
